@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the lamp dimmer core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LDCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ldcm assertion failed");

// Next-cycle implication, disabled during reset.
`define LDCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ldcm assertion failed");

`endif

@@ sv/ldcm_pkg.sv @@
// ----------------------------------------------------------------------------
// ldcm_pkg
// Types, constants and helper functions shared by the lamp dimmer core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldcm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int LEVEL_W     = 16;
    localparam int TEMP_W      = 15;
    localparam int TIME_W      = 32;
    localparam int PROD_W      = 32;

    localparam int DIV_DEN_W = TEMP_W;
    localparam int DIV_QUO_W = LEVEL_W;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_QUO_W);

    // item commands
    localparam logic [2:0] CMD_LIGHTNESS   = 3'd0;
    localparam logic [2:0] CMD_TEMPERATURE = 3'd1;
    localparam logic [2:0] CMD_ATTENTION   = 3'd2;
    localparam logic [2:0] CMD_TICK        = 3'd3;
    localparam logic [2:0] CMD_START       = 3'd4;
    localparam logic [2:0] CMD_STOP        = 3'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CTL_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROVISIONED = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_FS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_MIN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_MAX    = 3'd4;

    localparam logic [LEVEL_W-1:0] PWM_FS_RESET = 16'd65535;
    localparam logic [TEMP_W-1:0]  TEMP_MIN_RESET = 15'd2700;
    localparam logic [TEMP_W-1:0]  TEMP_MAX_RESET = 15'd6500;

    localparam logic [LEVEL_W-1:0] ATT_HIGH   = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] ATT_LOW    = 16'((65535 * 4) / 10);
    localparam logic [LEVEL_W-1:0] IDLE_LEVEL = 16'hFFFF;
    localparam logic [PROD_W-1:0]  LIN_BIAS   = 32'd65534;
    localparam logic [16:0]        LIN_DIV    = 17'd65535;

    localparam int NUM_STAGES = 5;
    localparam logic [TIME_W-1:0] STAGE_END [NUM_STAGES] =
        '{32'd3000, 32'd4000, 32'd5000, 32'd6000, 32'd36000};
    localparam logic [LEVEL_W-1:0] STAGE_LEVEL [NUM_STAGES] =
        '{16'hB504, 16'h18FF, 16'hFFFF, 16'h18FF, 16'hFFFF};

    typedef enum logic [2:0] {
        LVL_MSG,
        LVL_STORED,
        LVL_ATT,
        LVL_STAGE,
        LVL_IDLE
    } lvl_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START_TIME,
        OP_APPLY,
        OP_SQUARE,
        OP_BIAS,
        OP_LINEAR,
        OP_PWM_MUL,
        OP_PWM_DIV,
        OP_SINGLE,
        OP_CLAMP,
        OP_WARM_MUL,
        OP_COLD_MUL,
        OP_DIV_START,
        OP_WARM_CAP,
        OP_COLD_CAP
    } dp_op_t;

    typedef struct packed {
        dp_op_t   op;
        lvl_sel_t lvl_sel;
        logic     store_l;
        logic     store_t;
        logic     load_out;
        logic     wrote;
        logic     finished;
        logic     sensor;
        logic     seq_active;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       length_ok;
        logic       attention_on;
        logic       provisioned;
        logic       seq_end;
        logic       ctl_mode;
        logic       range_empty;
        logic       temp_zero;
        logic       div_done;
    } dp_stat_t;

    // floor(x / 65535) for x below 2^32 - 65535
    function automatic logic [LEVEL_W-1:0] div_by_65535(input logic [PROD_W-1:0] x);
        logic [LEVEL_W-1:0] q;
        logic [16:0]        r;
        q = x[31:16];
        r = {1'b0, x[15:0]} + {1'b0, q};
        if (r >= LIN_DIV)
            q = q + 16'd1;
        return q;
    endfunction

    function automatic logic [LEVEL_W-1:0] stage_level(input logic [TIME_W-1:0] elapsed);
        logic [LEVEL_W-1:0] lvl;
        lvl = IDLE_LEVEL;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            if (elapsed < STAGE_END[i])
                lvl = STAGE_LEVEL[i];
        end
        return lvl;
    endfunction

endpackage

@@ sv/ldcm_divider.sv @@
// ----------------------------------------------------------------------------
// ldcm_divider
// Restoring divider, one quotient bit per cycle, for the warm/cold split.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ldcm_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ldcm_pkg::DIV_NUM_W-1:0] numerator,
    input  logic [ldcm_pkg::DIV_DEN_W-1:0] divisor,
    output logic                           done,
    output logic [ldcm_pkg::DIV_QUO_W-1:0] quotient
);
    import ldcm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] div_reg, div_next;
    logic [DIV_QUO_W-1:0] bits_reg, bits_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 take;

    // numerator upper part is below the divisor, so the quotient fits
    always_comb
    begin
        trial     = {rem_reg, bits_reg[DIV_QUO_W-1]};
        take      = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        bits_next = bits_reg;
        if (start)
        begin
            rem_next  = numerator[DIV_NUM_W-1 -: DIV_DEN_W];
            bits_next = numerator[DIV_QUO_W-1:0];
            div_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_QUO_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? DIV_DEN_W'(trial - {1'b0, div_reg}) : trial[DIV_DEN_W-1:0];
            bits_next = {bits_reg[DIV_QUO_W-2:0], take};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        bits_reg <= bits_next;
    end

    assign done     = done_reg;
    assign quotient = bits_reg;

    `LDCM_ASSERT_IMPL(a_rem_below_div, clk, rst_n, busy_reg, rem_reg < div_reg)
    `LDCM_ASSERT_NEXT(a_start_runs, clk, rst_n, start, busy_reg && !done_reg)
    `LDCM_ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, !busy_reg)

endmodule

@@ sv/ldcm_datapath.sv @@
// ----------------------------------------------------------------------------
// ldcm_datapath
// Config and lamp state registers, shared multiplier, constant divide and
// the warm/cold split divider, plus the result word registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldcm_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ldcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ldcm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [2:0]                       cmd,
    input  logic [15:0]                      message_value,
    input  logic                             length_ok,
    input  logic                             attention_on,
    input  logic                             led_on,
    input  logic [31:0]                      now_ms,
    input  ldcm_pkg::dp_cmd_t                ctl,
    output ldcm_pkg::dp_stat_t               stat,
    output logic                             duty_written,
    output logic [15:0]                      cold_duty,
    output logic [15:0]                      warm_duty,
    output logic [15:0]                      linear_level,
    output logic                             startup_finished,
    output logic                             sensor_enable,
    output logic                             sequence_active
);
    import ldcm_pkg::*;

    // configuration
    logic               ctl_mode_reg;
    logic               provisioned_reg;
    logic [LEVEL_W-1:0] pwm_fs_reg;
    logic [TEMP_W-1:0]  tmin_reg;
    logic [TEMP_W-1:0]  tmax_reg;

    // captured item
    logic [2:0]         cmd_reg;
    logic [LEVEL_W-1:0] msg_reg;
    logic               len_ok_reg;
    logic               att_on_reg;
    logic               led_reg;
    logic [TIME_W-1:0]  now_reg;

    // lamp state
    logic [LEVEL_W-1:0] stored_l_reg;
    logic [LEVEL_W-1:0] stored_t_reg;
    logic [LEVEL_W-1:0] lin_reg;
    logic [TIME_W-1:0]  start_reg;

    // work registers
    logic [LEVEL_W-1:0] level_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [LEVEL_W-1:0] pwm_reg;
    logic [TEMP_W-1:0]  wspan_reg;
    logic [TEMP_W-1:0]  cspan_reg;
    logic [LEVEL_W-1:0] cold_reg;
    logic [LEVEL_W-1:0] warm_reg;

    logic [TIME_W-1:0]  elapsed;
    logic [LEVEL_W-1:0] sel_level;
    logic [LEVEL_W-1:0] mul_a;
    logic [LEVEL_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [TEMP_W-1:0]  t_clamp;
    logic [TEMP_W-1:0]  span;
    logic               div_done;
    logic [LEVEL_W-1:0] quo;

    assign elapsed = now_reg - start_reg;
    assign span    = tmax_reg - tmin_reg;

    always_comb
    begin
        case (ctl.lvl_sel)
            LVL_MSG:    sel_level = msg_reg;
            LVL_STORED: sel_level = stored_l_reg;
            LVL_ATT:    sel_level = led_reg ? ATT_HIGH : ATT_LOW;
            LVL_STAGE:  sel_level = stage_level(elapsed);
            LVL_IDLE:   sel_level = IDLE_LEVEL;
            default:    sel_level = IDLE_LEVEL;
        endcase
    end

    always_comb
    begin
        case (ctl.op)
            OP_SQUARE:
            begin
                mul_a = level_reg;
                mul_b = level_reg;
            end
            OP_PWM_MUL:
            begin
                mul_a = lin_reg;
                mul_b = pwm_fs_reg;
            end
            OP_WARM_MUL:
            begin
                mul_a = {1'b0, wspan_reg};
                mul_b = pwm_reg;
            end
            default:
            begin
                mul_a = {1'b0, cspan_reg};
                mul_b = pwm_reg;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb
    begin
        if (stored_t_reg < {1'b0, tmin_reg})
            t_clamp = tmin_reg;
        else if (stored_t_reg > {1'b0, tmax_reg})
            t_clamp = tmax_reg;
        else
            t_clamp = stored_t_reg[TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_mode_reg    <= 1'b0;
            provisioned_reg <= 1'b0;
            pwm_fs_reg      <= PWM_FS_RESET;
            tmin_reg        <= TEMP_MIN_RESET;
            tmax_reg        <= TEMP_MAX_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CTL_MODE:    ctl_mode_reg    <= cfg_data[0];
                CFG_PROVISIONED: provisioned_reg <= cfg_data[0];
                CFG_PWM_FS:      pwm_fs_reg      <= cfg_data;
                CFG_TEMP_MIN:    tmin_reg        <= cfg_data[TEMP_W-1:0];
                CFG_TEMP_MAX:    tmax_reg        <= cfg_data[TEMP_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_l_reg <= '0;
            stored_t_reg <= '0;
            lin_reg      <= '0;
            start_reg    <= '0;
        end
        else
        begin
            if (ctl.op == OP_START_TIME)
                start_reg <= now_reg;
            if (ctl.op == OP_APPLY && ctl.store_l)
                stored_l_reg <= sel_level;
            if (ctl.op == OP_APPLY && ctl.store_t)
                stored_t_reg <= msg_reg;
            if (ctl.op == OP_LINEAR)
                lin_reg <= div_by_65535(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LOAD:
            begin
                cmd_reg    <= cmd;
                msg_reg    <= message_value;
                len_ok_reg <= length_ok;
                att_on_reg <= attention_on;
                led_reg    <= led_on;
                now_reg    <= now_ms;
            end
            OP_APPLY:    level_reg <= sel_level;
            OP_SQUARE:   prod_reg  <= mul_p;
            OP_BIAS:     prod_reg  <= prod_reg + LIN_BIAS;
            OP_PWM_MUL:  prod_reg  <= mul_p;
            OP_PWM_DIV:  pwm_reg   <= div_by_65535(prod_reg);
            OP_SINGLE:
            begin
                cold_reg <= pwm_reg;
                warm_reg <= '0;
            end
            OP_CLAMP:
            begin
                wspan_reg <= tmax_reg - t_clamp;
                cspan_reg <= t_clamp - tmin_reg;
            end
            OP_WARM_MUL: prod_reg <= mul_p;
            OP_COLD_MUL: prod_reg <= mul_p;
            OP_WARM_CAP: warm_reg <= quo;
            OP_COLD_CAP: cold_reg <= quo;
            default:     ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            duty_written     <= ctl.wrote;
            cold_duty        <= ctl.wrote ? cold_reg : '0;
            warm_duty        <= ctl.wrote ? warm_reg : '0;
            linear_level     <= lin_reg;
            startup_finished <= ctl.finished;
            sensor_enable    <= ctl.sensor;
            sequence_active  <= ctl.seq_active;
        end
    end

    ldcm_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.op == OP_DIV_START),
        .numerator (prod_reg[DIV_NUM_W-1:0]),
        .divisor   (span),
        .done      (div_done),
        .quotient  (quo)
    );

    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.length_ok    = len_ok_reg;
        stat.attention_on = att_on_reg;
        stat.provisioned  = provisioned_reg;
        stat.seq_end      = (elapsed >= STAGE_END[NUM_STAGES-1]);
        stat.ctl_mode     = ctl_mode_reg;
        stat.range_empty  = (tmax_reg <= tmin_reg);
        stat.temp_zero    = (stored_t_reg == '0);
        stat.div_done     = div_done;
    end

endmodule

@@ sv/ldcm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ldcm_ctrl
// Controller: item decode, lamp flags, and sequencing of the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ldcm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  ldcm_pkg::dp_stat_t stat,
    output ldcm_pkg::dp_cmd_t  ctl
);
    import ldcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DECIDE,
        S_SQUARE,
        S_BIAS,
        S_LINEAR,
        S_PMUL,
        S_PDIV,
        S_MODE,
        S_WMUL,
        S_WSTART,
        S_WDIV,
        S_CMUL,
        S_CSTART,
        S_CDIV,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   attention_reg, attention_next;
    logic   timer_reg, timer_next;
    logic   finished_reg, finished_next;
    logic   sensor_reg, sensor_next;
    logic   wrote_reg, wrote_next;

    logic     accept_msg;
    logic     dec_eval;
    logic     dec_drive;
    lvl_sel_t dec_lvl;
    logic     dec_store_l;
    logic     dec_store_t;
    logic     dec_att;
    logic     dec_timer;
    logic     dec_finished;
    logic     dec_sensor;

    // per-command decision
    always_comb
    begin
        accept_msg   = stat.provisioned || finished_reg;
        dec_eval     = 1'b0;
        dec_drive    = 1'b0;
        dec_lvl      = LVL_MSG;
        dec_store_l  = 1'b0;
        dec_store_t  = 1'b0;
        dec_att      = attention_reg;
        dec_timer    = timer_reg;
        dec_finished = finished_reg;
        dec_sensor   = 1'b0;
        case (stat.cmd)
            CMD_LIGHTNESS:
            begin
                if (accept_msg && stat.length_ok)
                begin
                    dec_store_l = 1'b1;
                    dec_drive   = !attention_reg;
                end
            end
            CMD_TEMPERATURE:
            begin
                if (accept_msg && stat.length_ok)
                begin
                    dec_store_t = 1'b1;
                    dec_lvl     = LVL_STORED;
                    dec_drive   = !attention_reg;
                end
            end
            CMD_ATTENTION:
            begin
                dec_att = stat.attention_on;
                if (stat.attention_on)
                begin
                    dec_drive = 1'b1;
                    dec_lvl   = LVL_ATT;
                end
                else if (attention_reg)
                begin
                    dec_drive = 1'b1;
                    dec_lvl   = LVL_STORED;
                end
            end
            CMD_TICK:
            begin
                dec_eval = timer_reg;
            end
            CMD_START:
            begin
                dec_timer = 1'b1;
                dec_eval  = 1'b1;
            end
            CMD_STOP:
            begin
                dec_timer    = 1'b0;
                dec_store_l  = 1'b1;
                dec_lvl      = LVL_IDLE;
                dec_drive    = !attention_reg;
                dec_finished = 1'b0;
            end
            default: ;
        endcase
        if (dec_eval)
        begin
            dec_store_l = 1'b1;
            dec_drive   = !attention_reg;
            if (!stat.seq_end)
                dec_lvl = LVL_STAGE;
            else
            begin
                dec_lvl      = LVL_IDLE;
                dec_timer    = 1'b0;
                dec_finished = 1'b1;
                dec_sensor   = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        attention_next = attention_reg;
        timer_next     = timer_reg;
        finished_next  = finished_reg;
        sensor_next    = sensor_reg;
        wrote_next     = wrote_reg;

        ctl.op         = OP_NONE;
        ctl.lvl_sel    = dec_lvl;
        ctl.store_l    = 1'b0;
        ctl.store_t    = 1'b0;
        ctl.load_out   = 1'b0;
        ctl.wrote      = wrote_reg;
        ctl.finished   = finished_reg;
        ctl.sensor     = sensor_reg;
        ctl.seq_active = timer_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (stat.cmd == CMD_START)
                    ctl.op = OP_START_TIME;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                ctl.op         = OP_APPLY;
                ctl.store_l    = dec_store_l;
                ctl.store_t    = dec_store_t;
                attention_next = dec_att;
                timer_next     = dec_timer;
                finished_next  = dec_finished;
                sensor_next    = dec_sensor;
                wrote_next     = 1'b0;
                state_next     = dec_drive ? S_SQUARE : S_OUT;
            end
            S_SQUARE:
            begin
                ctl.op     = OP_SQUARE;
                state_next = S_BIAS;
            end
            S_BIAS:
            begin
                ctl.op     = OP_BIAS;
                state_next = S_LINEAR;
            end
            S_LINEAR:
            begin
                ctl.op     = OP_LINEAR;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                ctl.op     = OP_PWM_MUL;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                ctl.op     = OP_PWM_DIV;
                state_next = S_MODE;
            end
            S_MODE:
            begin
                if (!stat.ctl_mode)
                begin
                    ctl.op     = OP_SINGLE;
                    wrote_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (stat.temp_zero)
                    state_next = S_OUT;
                else if (stat.range_empty)
                begin
                    ctl.op     = OP_SINGLE;
                    wrote_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    ctl.op     = OP_CLAMP;
                    state_next = S_WMUL;
                end
            end
            S_WMUL:
            begin
                ctl.op     = OP_WARM_MUL;
                state_next = S_WSTART;
            end
            S_WSTART:
            begin
                ctl.op     = OP_DIV_START;
                state_next = S_WDIV;
            end
            S_WDIV:
            begin
                if (stat.div_done)
                begin
                    ctl.op     = OP_WARM_CAP;
                    state_next = S_CMUL;
                end
            end
            S_CMUL:
            begin
                ctl.op     = OP_COLD_MUL;
                state_next = S_CSTART;
            end
            S_CSTART:
            begin
                ctl.op     = OP_DIV_START;
                state_next = S_CDIV;
            end
            S_CDIV:
            begin
                if (stat.div_done)
                begin
                    ctl.op     = OP_COLD_CAP;
                    wrote_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            attention_reg <= 1'b0;
            timer_reg     <= 1'b0;
            finished_reg  <= 1'b0;
            sensor_reg    <= 1'b0;
            wrote_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            attention_reg <= attention_next;
            timer_reg     <= timer_next;
            finished_reg  <= finished_next;
            sensor_reg    <= sensor_next;
            wrote_reg     <= wrote_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `LDCM_ASSERT_IMPL(a_sensor_ends_seq, clk, rst_n, sensor_reg, finished_reg && !timer_reg)
    `LDCM_ASSERT_IMPL(a_div_done_wait, clk, rst_n, stat.div_done, (state_reg == S_WDIV) || (state_reg == S_CDIV))
    `LDCM_ASSERT_NEXT(a_out_loaded, clk, rst_n, (state_reg == S_OUT) && !(out_valid_reg && out_stall), out_valid_reg && (state_reg == S_IDLE))

endmodule

@@ sv/lamp_dimmer_cct_mixer_core.sv @@
// ----------------------------------------------------------------------------
// lamp_dimmer_cct_mixer_core
// Dimmable lamp core: lightness to linear PWM duty with warm/cold mixing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command word: lightness or
//   temperature message, attention request, timer tick, startup start/stop.
//   Output channel (out_valid/out_stall) returns exactly one result word per
//   input word, in order.
//   From accept to result valid, words that do not drive the lamp pass
//   prep, decide and output; a drive in cold-only mode (or with an empty
//   temperature range) adds square, bias, linear, PWM mul/div; the warm/cold
//   split adds two 16-step passes through the shared restoring divider.
//   One word is processed at a time; the next word is taken the cycle after
//   the previous result is loaded into the output register.
//   The output register holds a stalled result; the next word is still
//   accepted and runs until its own result needs the output register.
//   Configuration writes (cfg_write/cfg_index/cfg_data) take effect at once
//   and are expected while the block is idle.
//   Reset clears the lamp state and flags and loads the default config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lamp_dimmer_cct_mixer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ldcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ldcm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       cmd,
    input  logic [15:0]                      message_value,
    input  logic                             length_ok,
    input  logic                             attention_on,
    input  logic                             led_on,
    input  logic [31:0]                      now_ms,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             duty_written,
    output logic [15:0]                      cold_duty,
    output logic [15:0]                      warm_duty,
    output logic [15:0]                      linear_level,
    output logic                             startup_finished,
    output logic                             sensor_enable,
    output logic                             sequence_active
);
    import ldcm_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    ldcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    ldcm_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .message_value    (message_value),
        .length_ok        (length_ok),
        .attention_on     (attention_on),
        .led_on           (led_on),
        .now_ms           (now_ms),
        .ctl              (ctl),
        .stat             (stat),
        .duty_written     (duty_written),
        .cold_duty        (cold_duty),
        .warm_duty        (warm_duty),
        .linear_level     (linear_level),
        .startup_finished (startup_finished),
        .sensor_enable    (sensor_enable),
        .sequence_active  (sequence_active)
    );

endmodule
